// File: rtl/mmrc_pkg.sv
// ----------------------------------------------------------------------------
// mmrc_pkg
// Shared types and codes of the memory map range checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mmrc_pkg;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_CHECK = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_UNAVAIL = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_EMPTY   = 2'd3;

    localparam logic [64:0] FOUR_GIB = 65'h1_0000_0000;
    localparam int          MB_SHIFT = 20;
    localparam int          SUM_W    = 40;
    localparam int          MB_W     = 20;

    typedef struct packed {
        logic [63:0] base;
        logic [63:0] top;
        logic        wrap;
        logic        len_nz;
        logic        usable;
        logic        en;
    } desc_entry_t;

    typedef struct packed {
        logic done;
        logic fail;
    } scan_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP,
        ST_ACC,
        ST_CHECK,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_RES,
        SC_COV
    } scan_state_t;

endpackage

`default_nettype wire

// File: rtl/mmrc_desc_ram.sv
// ----------------------------------------------------------------------------
// mmrc_desc_ram
// Descriptor table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmrc_desc_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  wire                        clk,
    input  wire                        wr_en,
    input  wire  [ADDR_W-1:0]          wr_addr,
    input  wire mmrc_pkg::desc_entry_t wr_data,
    input  wire                        rd_en,
    input  wire  [ADDR_W-1:0]          rd_addr,
    output mmrc_pkg::desc_entry_t      rd_data
);

    mmrc_pkg::desc_entry_t mem [DEPTH];
    mmrc_pkg::desc_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/mmrc_scan.sv
// ----------------------------------------------------------------------------
// mmrc_scan
// Range check engine: one reservation pass over the table, then coverage
// passes that walk a cursor from the range start along usable descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

module mmrc_scan #(
    parameter int CNT_W  = 8,
    parameter int ADDR_W = 7
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    input  wire  [31:0]                range_start,
    input  wire  [31:0]                range_end,
    input  wire  [CNT_W-1:0]           count,
    output logic                       rd_en,
    output logic [ADDR_W-1:0]          rd_addr,
    input  wire mmrc_pkg::desc_entry_t rd_data,
    output mmrc_pkg::scan_result_t     result
);

    mmrc_pkg::scan_state_t phase_reg, phase_next;
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]      pass_reg, pass_next;
    logic                  pend_reg, pend_next;
    logic                  fail_reg, fail_next;
    logic [31:0]           start_reg, start_next;
    logic [31:0]           end_reg, end_next;
    logic [63:0]           cursor_reg, cursor_next;
    logic [63:0]           next_reg, next_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= mmrc_pkg::SC_IDLE;
            rd_idx_reg <= '0;
            pass_reg   <= '0;
            pend_reg   <= 1'b0;
            fail_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            rd_idx_reg <= rd_idx_next;
            pass_reg   <= pass_next;
            pend_reg   <= pend_next;
            fail_reg   <= fail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg  <= start_next;
        end_reg    <= end_next;
        cursor_reg <= cursor_next;
        next_reg   <= next_next;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        rd_idx_next = rd_idx_reg;
        pass_next   = pass_reg;
        pend_next   = pend_reg;
        fail_next   = fail_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        cursor_next = cursor_reg;
        next_next   = next_reg;
        rd_en       = 1'b0;
        rd_addr     = rd_idx_reg[ADDR_W-1:0];
        result      = '0;

        case (phase_reg)
            mmrc_pkg::SC_IDLE:
            begin
                pend_next = 1'b0;
                if (start)
                begin
                    start_next  = range_start;
                    end_next    = range_end;
                    cursor_next = {32'd0, range_start};
                    rd_idx_next = '0;
                    fail_next   = 1'b0;
                    phase_next  = mmrc_pkg::SC_RES;
                end
            end
            mmrc_pkg::SC_RES, mmrc_pkg::SC_COV:
            begin
                // issue the next read
                rd_en     = (rd_idx_reg != count);
                pend_next = rd_en;
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end

                // evaluate the item read last cycle
                if (pend_reg)
                begin
                    if (phase_reg == mmrc_pkg::SC_RES)
                    begin
                        if (rd_data.en && rd_data.len_nz &&
                            (rd_data.wrap ||
                             (!rd_data.usable &&
                              rd_data.base < {32'd0, end_reg} &&
                              rd_data.top > {32'd0, start_reg})))
                        begin
                            fail_next = 1'b1;
                        end
                    end
                    else if (rd_data.usable && rd_data.en &&
                             rd_data.base <= cursor_reg && rd_data.top > next_reg)
                    begin
                        next_next = rd_data.top;
                    end
                end

                // end of a pass over the table
                if (rd_idx_reg == count && !pend_reg)
                begin
                    rd_idx_next = '0;
                    if (phase_reg == mmrc_pkg::SC_RES)
                    begin
                        if (fail_reg || cursor_reg >= {32'd0, end_reg})
                        begin
                            result.done = 1'b1;
                            result.fail = fail_reg;
                            phase_next  = mmrc_pkg::SC_IDLE;
                        end
                        else
                        begin
                            next_next  = cursor_reg;
                            pass_next  = '0;
                            phase_next = mmrc_pkg::SC_COV;
                        end
                    end
                    else if (next_reg == cursor_reg)
                    begin
                        result.done = 1'b1;
                        result.fail = 1'b1;
                        phase_next  = mmrc_pkg::SC_IDLE;
                    end
                    else
                    begin
                        cursor_next = next_reg;
                        if (pass_reg == count || next_reg >= {32'd0, end_reg})
                        begin
                            result.done = 1'b1;
                            result.fail = (next_reg < {32'd0, end_reg});
                            phase_next  = mmrc_pkg::SC_IDLE;
                        end
                        else
                        begin
                            pass_next = pass_reg + CNT_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                phase_next = mmrc_pkg::SC_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/memory_map_range_checker.sv
// ----------------------------------------------------------------------------
// memory_map_range_checker
// Firmware memory map table with descriptor load, clear and range check.
//
//  channel | direction | fields                                   | handshake
//  --------+-----------+------------------------------------------+--------------------
//  in      | input     | cmd entry_base entry_length entry_type   | in_valid/in_ready
//          |           | entry_enabled range_start range_end      |
//  out     | output    | status usable_mb entry_total             | out_valid/out_ready
//
//  Load: IDLE to FINISH, or through CLIP and ACC when the descriptor adds to the
//  usable sum. Clear: IDLE to FINISH. Check with N descriptors: each pass over
//  the table reads N descriptors through the one descriptor memory read port;
//  one reservation pass plus up to N+1 coverage passes.
//  Reset empties the table at once; the memory itself needs no clearing.
//  An item is taken while the previous result still waits; a finished
//  result holds the block until the previous one is taken with out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_map_range_checker #(
    parameter int MAP_ENTRIES = 128
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  cmd,
    input  wire  [63:0] entry_base,
    input  wire  [63:0] entry_length,
    input  wire  [31:0] entry_type,
    input  wire         entry_enabled,
    input  wire  [31:0] range_start,
    input  wire  [31:0] range_end,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [1:0]  status,
    output logic [19:0] usable_mb,
    output logic [7:0]  entry_total
);

    localparam int CNT_W  = $clog2(MAP_ENTRIES + 1);
    localparam int ADDR_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int SUM_W  = mmrc_pkg::SUM_W;

    mmrc_pkg::ctrl_state_t  state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [1:0]             stat_reg, stat_next;
    logic [31:0]            lbase_reg, lbase_next;
    logic [64:0]            ltop_reg, ltop_next;
    logic [32:0]            add_reg, add_next;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             status_reg, status_next;
    logic [19:0]            mb_reg, mb_next;
    logic [7:0]             total_reg, total_next;

    logic                   accept;
    logic [64:0]            top65;
    logic [32:0]            top_clip;
    logic [SUM_W:0]         sum_wide;
    logic [15:0]            count_ext;
    logic                   ram_wr;
    mmrc_pkg::desc_entry_t  ram_wdata;
    logic                   scan_start;
    logic                   ram_rd;
    logic [ADDR_W-1:0]      ram_raddr;
    mmrc_pkg::desc_entry_t  ram_rdata;
    mmrc_pkg::scan_result_t scan_res;

    assign accept    = in_valid && in_ready;
    assign top65     = {1'b0, entry_base} + {1'b0, entry_length};
    assign top_clip  = (ltop_reg > mmrc_pkg::FOUR_GIB) ? mmrc_pkg::FOUR_GIB[32:0]
                                                       : ltop_reg[32:0];
    assign sum_wide  = {1'b0, sum_reg} + (SUM_W + 1)'(add_reg);
    assign count_ext = 16'(count_next);

    assign ram_wdata.base   = entry_base;
    assign ram_wdata.top    = top65[63:0];
    assign ram_wdata.wrap   = top65[64];
    assign ram_wdata.len_nz = (entry_length != 64'd0);
    assign ram_wdata.usable = (entry_type == 32'd1);
    assign ram_wdata.en     = entry_enabled;

    mmrc_desc_ram #(
        .DEPTH  (MAP_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (ram_wdata),
        .rd_en   (ram_rd),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    mmrc_scan #(
        .CNT_W  (CNT_W),
        .ADDR_W (ADDR_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (scan_start),
        .range_start (range_start),
        .range_end   (range_end),
        .count       (count_reg),
        .rd_en       (ram_rd),
        .rd_addr     (ram_raddr),
        .rd_data     (ram_rdata),
        .result      (scan_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mmrc_pkg::ST_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stat_reg   <= stat_next;
        lbase_reg  <= lbase_next;
        ltop_reg   <= ltop_next;
        add_reg    <= add_next;
        status_reg <= status_next;
        mb_reg     <= mb_next;
        total_reg  <= total_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        stat_next      = stat_reg;
        lbase_next     = lbase_reg;
        ltop_next      = ltop_reg;
        add_next       = add_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        mb_next        = mb_reg;
        total_next     = total_reg;
        in_ready       = (state_reg == mmrc_pkg::ST_IDLE);
        ram_wr         = 1'b0;
        scan_start     = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            mmrc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    stat_next  = mmrc_pkg::STATUS_OK;
                    state_next = mmrc_pkg::ST_FINISH;
                    case (cmd)
                        mmrc_pkg::CMD_LOAD:
                        begin
                            if (count_reg == CNT_W'(MAP_ENTRIES))
                            begin
                                stat_next = mmrc_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ram_wr     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                lbase_next = entry_base[31:0];
                                ltop_next  = top65;
                                if (entry_type == 32'd1 && entry_enabled &&
                                    entry_base[63:32] == 32'd0)
                                begin
                                    state_next = mmrc_pkg::ST_CLIP;
                                end
                            end
                        end
                        mmrc_pkg::CMD_CHECK:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = mmrc_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                scan_start = 1'b1;
                                state_next = mmrc_pkg::ST_CHECK;
                            end
                        end
                        mmrc_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            sum_next   = '0;
                        end
                        default:
                        begin
                            stat_next = mmrc_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            mmrc_pkg::ST_CLIP:
            begin
                add_next   = top_clip - {1'b0, lbase_reg};
                state_next = mmrc_pkg::ST_ACC;
            end
            mmrc_pkg::ST_ACC:
            begin
                sum_next   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
                state_next = mmrc_pkg::ST_FINISH;
            end
            mmrc_pkg::ST_CHECK:
            begin
                if (scan_res.done)
                begin
                    stat_next  = scan_res.fail ? mmrc_pkg::STATUS_UNAVAIL
                                               : mmrc_pkg::STATUS_OK;
                    state_next = mmrc_pkg::ST_FINISH;
                end
            end
            mmrc_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = stat_reg;
                    mb_next        = sum_reg[SUM_W-1:mmrc_pkg::MB_SHIFT];
                    total_next     = count_ext[7:0];
                    state_next     = mmrc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mmrc_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign usable_mb   = mb_reg;
    assign entry_total = total_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAP_ENTRIES))
        else $error("descriptor count beyond table size");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == mmrc_pkg::CMD_LOAD && count_reg == CNT_W'(MAP_ENTRIES)
        |=> $stable(count_reg) && $stable(sum_reg))
        else $error("load into full table changed state");

    a_scan_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        scan_res.done |-> state_reg == mmrc_pkg::ST_CHECK)
        else $error("scan finished outside a range check");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr |-> !ram_rd && state_reg == mmrc_pkg::ST_IDLE)
        else $error("table written while a scan reads it");

endmodule

`default_nettype wire
